// ----- src/rfa_pkg.sv -----
// Shared types and constants for the rational fraction ALU.
package rfa_pkg;

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_CMP = 3'd4;
    localparam logic [2:0] MODE_ABS = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam int W = 66;

    typedef enum logic [3:0] {
        OP_IDLE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_MUL    = 4'd2,
        OP_COMB   = 4'd3,
        OP_PREP   = 4'd4,
        OP_GCD    = 4'd5,
        OP_DIVSET = 4'd6,
        OP_DIV    = 4'd7,
        OP_FINISH = 4'd8
    } t_op;

    typedef struct packed {
        t_op  op;
        logic mul_sel;
        logic div_sel;
    } t_cmd;

    typedef struct packed {
        logic short_done;
        logic gcd_done;
        logic div_done;
    } t_status;

endpackage

// ----- src/rfa_datapath.sv -----
// Datapath: cross products, sign handling, binary gcd and restoring division.
module rfa_datapath #(
    parameter int INT_BITS = 32
) (
    input  logic                  i_clk,
    input  rfa_pkg::t_cmd         i_cmd,
    output rfa_pkg::t_status      o_stat,
    input  logic [2:0]            i_mode,
    input  logic signed [31:0]    i_a_num,
    input  logic [30:0]           i_a_den,
    input  logic signed [31:0]    i_b_num,
    input  logic [30:0]           i_b_den,
    output logic signed [31:0]    o_res_num,
    output logic [30:0]           o_res_den,
    output logic [1:0]            o_status,
    output logic                  o_is_less,
    output logic                  o_is_equal
);
    localparam int W = rfa_pkg::W;
    localparam logic [W-1:0] LIM = W'(1) << (INT_BITS - 1);

    logic [2:0]          r_mode;
    logic signed [31:0]  r_an, r_bn;
    logic [30:0]         r_ad, r_bd;
    logic signed [W-1:0] r_p0, r_p1, r_n, r_d;
    logic [W-1:0]        r_x, r_y, r_mn, r_md, r_g;
    logic [6:0]          r_k;
    logic                r_neg, r_early;
    logic [1:0]          r_st;
    logic [W-1:0]        r_q, r_rem;
    logic [6:0]          r_cnt;

    logic signed [32:0]  m_a, m_b;
    logic signed [65:0]  m_p;
    logic [W:0]          trial;
    logic [W-1:0]        rmag, dmag;
    logic [W-1:0]        diff;
    logic                ovf;

    always_comb begin
        unique case (i_cmd.mul_sel)
            1'b0: begin m_a = 33'(r_an); m_b = $signed({2'b00, r_bd}); end
            default: begin
                if (r_mode == rfa_pkg::MODE_MUL) begin
                    m_a = 33'(r_ad); m_b = $signed({2'b00, r_bd});
                end else if (r_mode == rfa_pkg::MODE_DIV) begin
                    m_a = 33'(r_bn); m_b = $signed({2'b00, r_ad});
                end else begin
                    m_a = 33'(r_bn); m_b = $signed({2'b00, r_ad});
                end
            end
        endcase
        if (!i_cmd.mul_sel && r_mode == rfa_pkg::MODE_MUL) m_b = 33'(r_bn);
        m_p   = m_a * m_b;
        trial = {r_rem, r_q[W-1]} - {1'b0, r_g};
        rmag  = r_n[W-1] ? W'(-r_n) : W'(r_n);
        dmag  = r_d[W-1] ? W'(-r_d) : W'(r_d);
        diff  = (r_x > r_y) ? r_x - r_y : r_y - r_x;
        ovf   = r_md > LIM - 1 || (r_neg ? r_mn > LIM : r_mn > LIM - 1);
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            rfa_pkg::OP_LOAD: begin
                r_mode <= i_mode;
                r_an <= i_a_num; r_ad <= i_a_den;
                r_bn <= i_b_num; r_bd <= i_b_den;
            end
            rfa_pkg::OP_MUL: begin
                if (i_cmd.mul_sel) r_p1 <= m_p; else r_p0 <= m_p;
            end
            rfa_pkg::OP_COMB: begin
                r_early <= !(r_mode inside {rfa_pkg::MODE_ADD, rfa_pkg::MODE_SUB,
                                            rfa_pkg::MODE_MUL, rfa_pkg::MODE_DIV,
                                            rfa_pkg::MODE_ABS})
                           || (r_mode == rfa_pkg::MODE_DIV && r_bn == 0);
                r_st <= (r_mode == rfa_pkg::MODE_DIV && r_bn == 0) ? rfa_pkg::ST_DIVZ
                                                                    : rfa_pkg::ST_OK;
                o_is_less <= (r_mode == rfa_pkg::MODE_CMP) && (r_p0 < r_p1);
                o_is_equal <= (r_mode == rfa_pkg::MODE_CMP) && (r_p0 == r_p1);
                unique case (r_mode)
                    rfa_pkg::MODE_ADD: begin
                        r_n <= r_p0 + r_p1;
                        r_d <= W'(r_ad) * W'(r_bd);
                    end
                    rfa_pkg::MODE_SUB: begin
                        r_n <= r_p0 - r_p1;
                        r_d <= W'(r_ad) * W'(r_bd);
                    end
                    rfa_pkg::MODE_MUL: begin r_n <= r_p0; r_d <= r_p1; end
                    rfa_pkg::MODE_DIV: begin r_n <= r_p0; r_d <= r_p1; end
                    rfa_pkg::MODE_ABS: begin
                        r_n <= (r_an < 0) ? -W'(r_an) : W'(r_an);
                        r_d <= W'(r_ad);
                    end
                    default: begin r_n <= '0; r_d <= W'(1); end
                endcase
            end
            rfa_pkg::OP_PREP: begin
                r_neg <= r_n[W-1] ^ r_d[W-1];
                r_mn <= rmag; r_md <= dmag;
                r_x <= rmag; r_y <= dmag; r_k <= '0;
                if (r_d == 0) begin
                    r_early <= 1'b1; r_st <= rfa_pkg::ST_DIVZ;
                end else if (r_n == 0) begin
                    r_early <= 1'b1;
                end
            end
            rfa_pkg::OP_GCD: begin
                if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1; r_y <= r_y >> 1; r_k <= r_k + 7'd1;
                end else if (!r_x[0]) r_x <= r_x >> 1;
                else if (!r_y[0]) r_y <= r_y >> 1;
                else if (r_x > r_y) r_x <= diff;
                else r_y <= diff;
                if (r_x == r_y) r_g <= r_x << r_k;
            end
            rfa_pkg::OP_DIVSET: begin
                r_q <= i_cmd.div_sel ? r_md : r_mn;
                r_rem <= '0; r_cnt <= '0;
            end
            rfa_pkg::OP_DIV: begin
                r_cnt <= r_cnt + 7'd1;
                if (!trial[W]) begin
                    r_rem <= trial[W-1:0]; r_q <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[W-2:0], r_q[W-1]}; r_q <= {r_q[W-2:0], 1'b0};
                end
                if (r_cnt == 7'(W - 1)) begin
                    if (i_cmd.div_sel) r_md <= {r_q[W-2:0], ~trial[W]};
                    else r_mn <= {r_q[W-2:0], ~trial[W]};
                end
            end
            rfa_pkg::OP_FINISH: begin
                if (!r_early && !ovf) begin
                    o_status <= rfa_pkg::ST_OK;
                    o_res_num <= r_neg ? -r_mn[31:0] : r_mn[31:0];
                    o_res_den <= r_md[30:0];
                end else begin
                    o_status <= r_early ? r_st : rfa_pkg::ST_OVF;
                    o_res_num <= '0;
                    o_res_den <= 31'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.short_done = r_early;
    assign o_stat.gcd_done   = (r_x == r_y);
    assign o_stat.div_done   = (r_cnt == 7'(W - 1));
endmodule

// ----- src/rfa_ctrl.sv -----
// Controller state machine sequencing the fraction datapath.
module rfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output rfa_pkg::t_cmd     o_cmd,
    input  rfa_pkg::t_status  i_stat
);
    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001, S_MUL0 = 10'b0000000010, S_MUL1 = 10'b0000000100,
        S_COMB = 10'b0000001000, S_PREP = 10'b0000010000, S_GCD  = 10'b0000100000,
        S_DS0  = 10'b0001000000, S_DV0  = 10'b0010000000, S_DS1  = 10'b0100000000,
        S_DV1  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_fin, r_out, n_fin;

    always_comb begin
        n_state = r_state;
        n_fin = 1'b0;
        o_cmd = '{op: rfa_pkg::OP_IDLE, mul_sel: 1'b0, div_sel: 1'b0};
        unique case (r_state)
            S_IDLE: if (i_valid && o_ready) begin
                o_cmd.op = rfa_pkg::OP_LOAD; n_state = S_MUL0;
            end
            S_MUL0: begin o_cmd.op = rfa_pkg::OP_MUL; n_state = S_MUL1; end
            S_MUL1: begin
                o_cmd.op = rfa_pkg::OP_MUL; o_cmd.mul_sel = 1'b1; n_state = S_COMB;
            end
            S_COMB: begin o_cmd.op = rfa_pkg::OP_COMB; n_state = S_PREP; end
            S_PREP: begin
                if (i_stat.short_done) begin
                    n_fin = 1'b1; n_state = S_IDLE;
                end else begin
                    o_cmd.op = rfa_pkg::OP_PREP; n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (i_stat.short_done) begin
                    n_fin = 1'b1; n_state = S_IDLE;
                end else begin
                    o_cmd.op = rfa_pkg::OP_GCD;
                    if (i_stat.gcd_done) n_state = S_DS0;
                end
            end
            S_DS0: begin o_cmd.op = rfa_pkg::OP_DIVSET; n_state = S_DV0; end
            S_DV0: begin
                o_cmd.op = rfa_pkg::OP_DIV;
                if (i_stat.div_done) n_state = S_DS1;
            end
            S_DS1: begin
                o_cmd.op = rfa_pkg::OP_DIVSET; o_cmd.div_sel = 1'b1; n_state = S_DV1;
            end
            S_DV1: begin
                o_cmd.op = rfa_pkg::OP_DIV; o_cmd.div_sel = 1'b1;
                if (i_stat.div_done) begin n_fin = 1'b1; n_state = S_IDLE; end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_fin) o_cmd.op = rfa_pkg::OP_FINISH;
    end

    assign o_ready = (r_state == S_IDLE) && !r_fin && (!r_out || i_ready);
    assign o_valid = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_fin <= 1'b0; r_out <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin <= n_fin;
            if (r_fin) r_out <= 1'b1;
            else if (i_ready) r_out <= 1'b0;
        end
    end
endmodule

// ----- src/rational_fraction_alu.sv -----
// Top level of the rational fraction ALU.
// Channel | Direction | Signals
// request | in        | i_valid/o_ready, i_mode, i_a_num, i_a_den, i_b_num, i_b_den
// result  | out       | o_valid/i_ready, o_res_num, o_res_den, o_status, o_is_less, o_is_equal
// Compare, unused modes and a zero divisor finish after the combine step, a zero
// numerator or denominator after the prepare step; otherwise the binary gcd loop runs, then
// the shared restoring divider divides the numerator and then the denominator by the gcd.
// Reset is synchronous; one request is worked on at a time, and the next is
// taken once the previous result has left or is being taken.
module rational_fraction_alu #(
    parameter int INT_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_a_num,
    input  logic [30:0]        i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic [30:0]        i_b_den,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_res_num,
    output logic [30:0]        o_res_den,
    output logic [1:0]         o_status,
    output logic               o_is_less,
    output logic               o_is_equal
);
    rfa_pkg::t_cmd    w_cmd;
    rfa_pkg::t_status w_stat;

    rfa_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .o_cmd(w_cmd), .i_stat(w_stat)
    );

    rfa_datapath #(.INT_BITS(INT_BITS)) u_dp (
        .i_clk, .i_cmd(w_cmd), .o_stat(w_stat),
        .i_mode, .i_a_num, .i_a_den, .i_b_num, .i_b_den,
        .o_res_num, .o_res_den, .o_status, .o_is_less, .o_is_equal
    );
endmodule

// ----- src/rfa_checker.sv -----
// Port-level checks for the rational fraction ALU.
module rfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [30:0] o_res_den,
    input logic [1:0]  o_status,
    input logic        o_is_less,
    input logic        o_is_equal
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_den))
        else $error("result dropped while stalled");
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res_den != 31'd0)
        else $error("zero denominator");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_less && o_is_equal))
        else $error("less and equal both set");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("bad status");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request taken at once");
endmodule

bind rational_fraction_alu rfa_checker u_rfa_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
    .o_res_den, .o_status, .o_is_less, .o_is_equal
);

// ----- tb/sv/tb_rational_fraction_alu.sv -----
// Testbench for the rational fraction ALU: directed and random requests checked against a predictor.
module tb_rational_fraction_alu;

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic [1:0]         status;
        logic               is_less;
        logic               is_equal;
    } t_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_mode = 3'd0;
    logic signed [31:0] i_a_num = '0;
    logic [30:0]        i_a_den = 31'd1;
    logic signed [31:0] i_b_num = '0;
    logic [30:0]        i_b_den = 31'd1;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_res_num;
    logic [30:0]        o_res_den;
    logic [1:0]         o_status;
    logic               o_is_less;
    logic               o_is_equal;

    t_answer answers_due[$];
    int      errors = 0;
    int      cycles = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_off = 0;

    rational_fraction_alu uut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("[rational_fraction_alu] ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic t_answer reduce(longint n, longint d);
        t_answer     ans;
        logic        neg;
        logic [63:0] mn, md, g, lim;
        ans = '{num: '0, den: 31'd1, status: rfa_pkg::ST_OK, is_less: 1'b0, is_equal: 1'b0};
        if (d == 0) begin
            ans.status = rfa_pkg::ST_DIVZ;
            return ans;
        end
        neg = (n < 0) != (d < 0);
        mn = n < 0 ? -n : n;
        md = d < 0 ? -d : d;
        if (mn == 0) return ans;
        g = gcd_of(mn, md);
        mn = mn / g;
        md = md / g;
        lim = 64'd1 << 31;
        if (md > lim - 1 || (neg ? mn > lim : mn > lim - 1)) begin
            ans.status = rfa_pkg::ST_OVF;
            return ans;
        end
        ans.num = neg ? -mn[31:0] : mn[31:0];
        ans.den = md[30:0];
        return ans;
    endfunction

    function automatic t_answer fraction_result(logic [2:0] mode, logic signed [31:0] an,
                                                logic [30:0] ad, logic signed [31:0] bn,
                                                logic [30:0] bd);
        t_answer ans;
        longint  lan, lad, lbn, lbd;
        lan = an; lad = {33'd0, ad}; lbn = bn; lbd = {33'd0, bd};
        ans = '{num: '0, den: 31'd1, status: rfa_pkg::ST_OK, is_less: 1'b0, is_equal: 1'b0};
        case (mode)
            rfa_pkg::MODE_ADD: ans = reduce(lan * lbd + lbn * lad, lad * lbd);
            rfa_pkg::MODE_SUB: ans = reduce(lan * lbd - lbn * lad, lad * lbd);
            rfa_pkg::MODE_MUL: ans = reduce(lan * lbn, lad * lbd);
            rfa_pkg::MODE_DIV: begin
                if (lbn == 0) ans.status = rfa_pkg::ST_DIVZ;
                else ans = reduce(lan * lbd, lad * lbn);
            end
            rfa_pkg::MODE_CMP: begin
                ans.is_less = (lan * lbd) < (lbn * lad);
                ans.is_equal = (lan * lbd) == (lbn * lad);
            end
            rfa_pkg::MODE_ABS: ans = reduce(lan < 0 ? -lan : lan, lad);
            default: ;
        endcase
        return ans;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (answers_due.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                want = answers_due.pop_front();
                if (o_res_num !== want.num) report("res_num", o_res_num, want.num);
                if (o_res_den !== want.den) report("res_den", o_res_den, want.den);
                if (o_status !== want.status) report("status", o_status, want.status);
                if (o_is_less !== want.is_less) report("is_less", o_is_less, want.is_less);
                if (o_is_equal !== want.is_equal) report("is_equal", o_is_equal, want.is_equal);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(logic [2:0] mode, logic signed [31:0] an, logic [30:0] ad,
                                logic signed [31:0] bn, logic [30:0] bd);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        answers_due.push_back(fraction_result(mode, an, ad, bn, bd));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_num();
        case ($urandom_range(5))
            0: return $signed($urandom_range(20)) - 10;
            1: return 32'sh8000_0000 + $urandom_range(3);
            2: return 32'sh7fff_ffff - $urandom_range(3);
            3: return $signed($urandom_range(2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_den();
        case ($urandom_range(5))
            0: return 31'($urandom_range(12, 1));
            1: return 31'(31'h7fff_ffff - $urandom_range(3));
            2: return 31'($urandom_range(1000, 1));
            3: return ($urandom_range(19) == 0) ? 31'd0 : 31'd1;
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [2:0] m;
        send_request(rfa_pkg::MODE_ADD, 1, 31'd2, 1, 31'd3);
        send_request(rfa_pkg::MODE_SUB, 1, 31'd2, 1, 31'd2);
        send_request(rfa_pkg::MODE_MUL, -4, 31'd6, 3, 31'd8);
        send_request(rfa_pkg::MODE_DIV, 1, 31'd2, 0, 31'd5);
        send_request(rfa_pkg::MODE_DIV, -3, 31'd7, -5, 31'd11);
        send_request(rfa_pkg::MODE_CMP, 1, 31'd3, 1, 31'd2);
        send_request(rfa_pkg::MODE_CMP, 2, 31'd4, 1, 31'd2);
        send_request(rfa_pkg::MODE_CMP, 32'sh8000_0000, 31'd0, 32'sh7fff_ffff, 31'h7fff_ffff);
        send_request(rfa_pkg::MODE_ABS, 32'sh8000_0000, 31'd1, 0, 31'd1);
        send_request(rfa_pkg::MODE_ABS, -7, 31'd3, 0, 31'd1);
        send_request(rfa_pkg::MODE_ADD, 32'sh7fff_ffff, 31'd1, 32'sh7fff_ffff, 31'd1);
        send_request(rfa_pkg::MODE_MUL, 32'sh8000_0000, 31'd1, -1, 31'd1);
        send_request(rfa_pkg::MODE_MUL, 32'sh8000_0000, 31'd1, 1, 31'd1);
        send_request(rfa_pkg::MODE_ADD, 1, 31'h7fff_ffff, 1, 31'h7fff_fffe);
        send_request(rfa_pkg::MODE_ADD, 1, 31'd0, 1, 31'd3);
        send_request(rfa_pkg::MODE_DIV, 5, 31'd3, 2, 31'd0);
        send_request(rfa_pkg::MODE_ABS, 4, 31'd0, 0, 31'd1);
        send_request(rfa_pkg::MODE_SUB, 0, 31'h7fff_ffff, 0, 31'd1);
        send_request(3'd6, 5, 31'd3, 2, 31'd7);
        send_request(3'd7, -1, 31'h7fff_ffff, -1, 31'h7fff_ffff);
        for (int k = 0; k < 6; k++) begin
            m = k[2:0];
            send_request(m, -6, 31'd4, 9, 31'd6);
        end
        wait_drained();
    endtask

    task automatic test_random(int count, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < count; k++)
            send_request(3'($urandom_range(7)), pick_num(), pick_den(), pick_num(), pick_den());
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge i_clk);
        hold_off <= 1500;
        for (int k = 0; k < 10; k++)
            send_request(3'($urandom_range(5)), pick_num(), pick_den(), pick_num(), pick_den());
        wait_drained();
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(110, 0, 0);
        test_random(110, 66, 0);
        test_random(110, 0, 66);
        test_backpressure();
        test_random(110, 17, 17);
        wait_drained();
        repeat (600) @(negedge i_clk);
        if (errors == 0) begin
            $display("[rational_fraction_alu] OK");
        end else begin
            $display("[rational_fraction_alu] ERROR");
        end
        $finish;
    end
endmodule
